// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and codes of the best-fit heap allocator.
`timescale 1ns / 1ps

package bfa_pkg;

   // Operation codes of a request transaction.
   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_FORMAT = 2'd2;

   // Status codes of a response transaction.
   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE     = 3'd1;
   localparam logic [2:0] ST_NO_FIT       = 3'd2;
   localparam logic [2:0] ST_BAD_ADDR     = 3'd3;
   localparam logic [2:0] ST_ALREADY_FREE = 3'd4;

   // Heap word constants.
   localparam logic [31:0] HEAP_TAIL = 32'd1;
   localparam logic [31:0] SIZE_MASK = 32'hFFFF_FFFC;
   localparam logic [16:0] REGION_RESET = 17'h1_0000;

   // Datapath commands issued by the controller.
   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_FMT_HDR,
      CMD_FMT_FTR,
      CMD_FMT_END,
      CMD_RD_POS,
      CMD_A_STEP,
      CMD_A_SPLIT_HDR,
      CMD_A_SPLIT_REM,
      CMD_A_SPLIT_FTR,
      CMD_A_TAKE,
      CMD_A_MARK,
      CMD_F_STEP,
      CMD_F_GRAB,
      CMD_F_NEXT,
      CMD_RD_PFTR,
      CMD_F_PMERGE,
      CMD_RD_H,
      CMD_F_PBIT,
      CMD_F_WHDR,
      CMD_F_WFTR,
      CMD_RESP
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic [2:0] status;
      logic       with_addr;
   } ctl_cmd_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic       at_end;
      logic       is_free;
      logic       addr_hit;
      logic       addr_passed;
      logic       found;
      logic       rem_big;
      logic       req_zero;
      logic       addr_bad;
      logic [1:0] op;
      logic       pfree_ok;
      logic       ps_ok;
      logic       rsp_free;
   } dp_stat_type;

endpackage

// ===== hw/rtl/bfa_req_if.sv =====
// Request channel interface of the allocator.
`timescale 1ns / 1ps

interface bfa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] req_bytes;
   logic [15:0] free_addr;

   modport source (output valid, output op, output req_bytes, output free_addr,
                   input ready);
   modport sink (input valid, input op, input req_bytes, input free_addr,
                 output ready);
endinterface

// ===== hw/rtl/bfa_rsp_if.sv =====
// Response channel interface of the allocator.
`timescale 1ns / 1ps

interface bfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_addr;
   logic [2:0]  status;

   modport source (output valid, output payload_addr, output status, input ready);
   modport sink (input valid, input payload_addr, input status, output ready);
endinterface

// ===== hw/rtl/best_fit_heap_allocator.sv =====
// Top level of the best-fit heap allocator.
//
// A request transaction on req_ch carries op (0 allocate, 1 free, 2 format),
// req_bytes and free_addr. Every request gives exactly one response
// transaction on rsp_ch with payload_addr and status. csr_wr_data sets the
// region size in bytes that format uses; write it only while the block is idle.
// One request is processed at a time. Allocate walks every block header in
// the heap; free walks the headers up to and including the target block and
// then merges it with its free neighbours; format writes the region anew.
// Each walk step is bounded by the single read port of the heap memory and
// its registered read data.
// After reset the heap is formatted as one free block over a 65536-byte region,
// while req_ch.ready is low. A response waits in an output
// register while rsp_ch is stalled; the next request is still accepted, and
// its completion waits until the earlier response has been taken.
`timescale 1ns / 1ps

module best_fit_heap_allocator import bfa_pkg::*; #(
   parameter int HEAP_WORDS = 16384
) (
   input  logic         clock,
   input  logic         reset,
   bfa_req_if.sink      req_ch,
   bfa_rsp_if.source    rsp_ch,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   bfa_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   bfa_datapath #(
      .HEAP_WORDS (HEAP_WORDS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_op           (req_ch.op),
      .req_bytes        (req_ch.req_bytes),
      .free_addr        (req_ch.free_addr),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_payload_addr (rsp_ch.payload_addr),
      .rsp_status       (rsp_ch.status)
   );

endmodule

// ===== hw/rtl/bfa_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bfa_datapath.sv =====
// Datapath of the allocator: heap memory, walk registers and response register.
`timescale 1ns / 1ps

module bfa_datapath import bfa_pkg::*; #(
   parameter int HEAP_WORDS = 16384
) (
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  ctl,
   output dp_stat_type  stat,
   input  logic [1:0]   req_op,
   input  logic [15:0]  req_bytes,
   input  logic [15:0]  free_addr,
   input  logic         csr_wr_en,
   input  logic [16:0]  csr_wr_data,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output logic [15:0]  rsp_payload_addr,
   output logic [2:0]   rsp_status
);

   localparam int IW = $clog2(HEAP_WORDS);
   localparam int PW = (IW + 3 > 18) ? IW + 3 : 18;
   localparam logic [32:0] MEM_BYTES = 33'(HEAP_WORDS) * 33'd4;
   localparam int MEM_ROUND = (HEAP_WORDS * 4) & ~7;
   localparam logic [16:0] CAP_BYTES = (MEM_ROUND > 65536) ? 17'h1_0000 : 17'(MEM_ROUND);

   logic [1:0]    op_ff, op_in;
   logic [15:0]   req_ff, req_in;
   logic [15:0]   addr_ff, addr_in;
   logic [PW-1:0] need_ff, need_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] best_ff, best_in;
   logic [PW-1:0] bsz_ff, bsz_in;
   logic          bpbit_ff, bpbit_in;
   logic          found_ff, found_in;
   logic [PW-1:0] h_ff, h_in;
   logic [PW-1:0] s_ff, s_in;
   logic          p_ff, p_in;
   logic [16:0]   region_ff;
   logic          inrange_ff;
   logic          rsp_valid_ff;
   logic [15:0]   rsp_addr_ff;
   logic [2:0]    rsp_status_ff;

   logic [31:0]   ram_q;
   logic [31:0]   rdata;
   logic [31:0]   w_size32;
   logic [PW-1:0] w_size;
   logic          at_end;
   logic          cand;
   logic [PW-1:0] rem;
   logic [17:0]   need18;
   logic [16:0]   r0, r1, r2, blk;
   logic          wr_req;
   logic [PW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [PW-1:0] rd_addr;
   logic          wr_ok, rd_ok;

   // Read data of an address beyond the memory reads as zero.
   assign rdata    = inrange_ff ? ram_q : 32'd0;
   assign w_size32 = rdata & SIZE_MASK;
   assign w_size   = w_size32[PW-1:0];
   assign at_end   = (rdata == HEAP_TAIL) || (w_size32 < 32'd8) ||
                     ((33'(pos_ff) + 33'(w_size32) + 33'd4) > MEM_BYTES);
   assign cand     = !at_end && !rdata[0] && (w_size >= need_ff) &&
                     (!found_ff || (w_size < bsz_ff));
   assign rem      = bsz_ff - need_ff;
   assign need18   = (18'(req_bytes) + 18'd11) & 18'h3_FFF8;

   // Region sizing for format.
   assign r0  = {region_ff[16:3], 3'b000};
   assign r1  = (r0 > CAP_BYTES) ? CAP_BYTES : r0;
   assign r2  = (r1 < 17'd16) ? 17'd16 : r1;
   assign blk = r2 - 17'd8;

   // Memory port selection.
   always_comb begin
      wr_req  = 1'b0;
      wr_addr = pos_ff;
      wr_data = 32'd0;
      rd_addr = pos_ff;
      case (ctl.cmd)
         CMD_FMT_HDR: begin
            wr_req  = 1'b1;
            wr_addr = PW'(4);
            wr_data = 32'(blk) | 32'd2;
         end
         CMD_FMT_FTR: begin
            wr_req  = 1'b1;
            wr_addr = PW'(blk);
            wr_data = 32'(blk);
         end
         CMD_FMT_END: begin
            wr_req  = 1'b1;
            wr_addr = PW'(blk) + PW'(4);
            wr_data = HEAP_TAIL;
         end
         CMD_A_SPLIT_HDR: begin
            wr_req  = 1'b1;
            wr_addr = best_ff;
            wr_data = 32'(need_ff) | {30'd0, bpbit_ff, 1'b1};
         end
         CMD_A_SPLIT_REM: begin
            wr_req  = 1'b1;
            wr_addr = best_ff + need_ff;
            wr_data = 32'(rem) | 32'd2;
         end
         CMD_A_SPLIT_FTR: begin
            wr_req  = 1'b1;
            wr_addr = best_ff + bsz_ff - PW'(4);
            wr_data = 32'(rem);
         end
         CMD_A_TAKE: begin
            wr_req  = 1'b1;
            wr_addr = best_ff;
            wr_data = 32'(bsz_ff) | {30'd0, bpbit_ff, 1'b1};
         end
         CMD_A_MARK: begin
            wr_req  = 1'b1;
            wr_data = rdata | 32'd2;
         end
         CMD_F_NEXT: begin
            wr_req  = 1'b1;
            wr_data = rdata & ~32'd2;
         end
         CMD_F_WHDR: begin
            wr_req  = 1'b1;
            wr_addr = h_ff;
            wr_data = 32'(s_ff) | {30'd0, p_ff, 1'b0};
         end
         CMD_F_WFTR: begin
            wr_req  = 1'b1;
            wr_addr = h_ff + s_ff - PW'(4);
            wr_data = 32'(s_ff);
         end
         CMD_RD_PFTR: rd_addr = h_ff - PW'(4);
         CMD_RD_H:    rd_addr = h_ff;
         default: ;
      endcase
   end

   assign wr_ok = wr_req && (wr_addr[PW-1:2] < (PW-2)'(HEAP_WORDS));
   assign rd_ok = rd_addr[PW-1:2] < (PW-2)'(HEAP_WORDS);

   bfa_ram #(
      .WIDTH (32),
      .DEPTH (HEAP_WORDS)
   ) u_heap (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr[IW+1:2]),
      .wr_data (wr_data),
      .rd_addr (rd_addr[IW+1:2]),
      .rd_data (ram_q)
   );

   // Next values of the walk and merge registers.
   always_comb begin
      op_in    = op_ff;
      req_in   = req_ff;
      addr_in  = addr_ff;
      need_in  = need_ff;
      pos_in   = pos_ff;
      best_in  = best_ff;
      bsz_in   = bsz_ff;
      bpbit_in = bpbit_ff;
      found_in = found_ff;
      h_in     = h_ff;
      s_in     = s_ff;
      p_in     = p_ff;
      case (ctl.cmd)
         CMD_LOAD: begin
            op_in    = req_op;
            req_in   = req_bytes;
            addr_in  = free_addr;
            need_in  = PW'(need18);
            pos_in   = PW'(4);
            found_in = 1'b0;
         end
         CMD_A_STEP: begin
            if (cand) begin
               found_in = 1'b1;
               best_in  = pos_ff;
               bsz_in   = w_size;
               bpbit_in = rdata[1];
            end
            pos_in = pos_ff + w_size;
         end
         CMD_A_TAKE:   pos_in = best_ff + bsz_ff;
         CMD_F_STEP:   pos_in = pos_ff + w_size;
         CMD_F_GRAB: begin
            h_in   = pos_ff;
            s_in   = w_size;
            p_in   = rdata[1];
            pos_in = pos_ff + w_size;
         end
         CMD_F_NEXT: begin
            if (!rdata[0]) begin
               s_in = s_ff + w_size;
            end
         end
         CMD_F_PMERGE: begin
            h_in = h_ff - w_size;
            s_in = s_ff + w_size;
         end
         CMD_F_PBIT:   p_in = rdata[1];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      req_ff     <= req_in;
      addr_ff    <= addr_in;
      need_ff    <= need_in;
      pos_ff     <= pos_in;
      best_ff    <= best_in;
      bsz_ff     <= bsz_in;
      bpbit_ff   <= bpbit_in;
      h_ff       <= h_in;
      s_ff       <= s_in;
      p_ff       <= p_in;
      inrange_ff <= rd_ok;
      if (ctl.cmd == CMD_RESP) begin
         rsp_addr_ff   <= ctl.with_addr ? 16'(best_ff + PW'(4)) : 16'd0;
         rsp_status_ff <= ctl.status;
      end
   end

   // Control state: found flag, region register and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         region_ff    <= REGION_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
         if (csr_wr_en) begin
            region_ff <= csr_wr_data;
         end
         if (ctl.cmd == CMD_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Status flags for the controller.
   always_comb begin
      stat.at_end      = at_end;
      stat.is_free     = !rdata[0];
      stat.addr_hit    = (pos_ff + PW'(4)) == PW'(addr_ff);
      stat.addr_passed = (pos_ff + PW'(4)) > PW'(addr_ff);
      stat.found       = found_ff;
      stat.rem_big     = rem >= PW'(8);
      stat.req_zero    = req_ff == 16'd0;
      stat.addr_bad    = (addr_ff == 16'd0) || (addr_ff[2:0] != 3'd0);
      stat.op          = op_ff;
      stat.pfree_ok    = !p_ff && (h_ff >= PW'(8));
      stat.ps_ok       = (w_size32 >= 32'd8) && (w_size32 <= 32'(h_ff - PW'(4)));
      stat.rsp_free    = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload_addr = rsp_addr_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

// ===== hw/rtl/bfa_controller.sv =====
// Controller state machine of the allocator.
`timescale 1ns / 1ps

module bfa_controller import bfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   typedef enum logic [4:0] {
      S_FMT_HDR,
      S_FMT_FTR,
      S_FMT_END,
      S_IDLE,
      S_DISPATCH,
      S_A_RD,
      S_A_EVAL,
      S_A_DECIDE,
      S_A_SPLIT_REM,
      S_A_SPLIT_FTR,
      S_A_RDNX,
      S_A_EVNX,
      S_F_RD,
      S_F_EVAL,
      S_F_RDNX,
      S_F_EVNX,
      S_F_CHKP,
      S_F_EVPF,
      S_F_RDH,
      S_F_PBIT,
      S_F_WHDR,
      S_F_WFTR,
      S_RESP
   } state_type;

   state_type  state_ff, state_in;
   logic       boot_ff, boot_in;
   logic [2:0] status_ff, status_in;
   logic       waddr_ff, waddr_in;
   dp_cmd_type cmd;

   // Next state and datapath command.
   always_comb begin
      state_in  = state_ff;
      boot_in   = boot_ff;
      status_in = status_ff;
      waddr_in  = waddr_ff;
      cmd       = CMD_NONE;
      unique case (state_ff)
         S_FMT_HDR: begin
            cmd      = CMD_FMT_HDR;
            state_in = S_FMT_FTR;
         end
         S_FMT_FTR: begin
            cmd      = CMD_FMT_FTR;
            state_in = S_FMT_END;
         end
         S_FMT_END: begin
            cmd       = CMD_FMT_END;
            boot_in   = 1'b0;
            status_in = ST_OK;
            waddr_in  = 1'b0;
            state_in  = boot_ff ? S_IDLE : S_RESP;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            waddr_in  = 1'b0;
            status_in = ST_OK;
            unique case (stat.op)
               OP_ALLOC: begin
                  if (stat.req_zero) begin
                     status_in = ST_BAD_SIZE;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_A_RD;
                  end
               end
               OP_FREE: begin
                  if (stat.addr_bad) begin
                     status_in = ST_BAD_ADDR;
                     state_in  = S_RESP;
                  end else begin
                     state_in = S_F_RD;
                  end
               end
               OP_FORMAT: state_in = S_FMT_HDR;
               default:   state_in = S_RESP;
            endcase
         end
         S_A_RD: begin
            cmd      = CMD_RD_POS;
            state_in = S_A_EVAL;
         end
         S_A_EVAL: begin
            if (stat.at_end) begin
               state_in = S_A_DECIDE;
            end else begin
               cmd      = CMD_A_STEP;
               state_in = S_A_RD;
            end
         end
         S_A_DECIDE: begin
            if (!stat.found) begin
               status_in = ST_NO_FIT;
               state_in  = S_RESP;
            end else if (stat.rem_big) begin
               cmd      = CMD_A_SPLIT_HDR;
               state_in = S_A_SPLIT_REM;
            end else begin
               cmd      = CMD_A_TAKE;
               state_in = S_A_RDNX;
            end
         end
         S_A_SPLIT_REM: begin
            cmd      = CMD_A_SPLIT_REM;
            state_in = S_A_SPLIT_FTR;
         end
         S_A_SPLIT_FTR: begin
            cmd       = CMD_A_SPLIT_FTR;
            waddr_in  = 1'b1;
            state_in  = S_RESP;
         end
         S_A_RDNX: begin
            cmd      = CMD_RD_POS;
            state_in = S_A_EVNX;
         end
         S_A_EVNX: begin
            if (!stat.at_end) begin
               cmd = CMD_A_MARK;
            end
            waddr_in = 1'b1;
            state_in = S_RESP;
         end
         S_F_RD: begin
            cmd      = CMD_RD_POS;
            state_in = S_F_EVAL;
         end
         S_F_EVAL: begin
            if (stat.at_end) begin
               status_in = ST_BAD_ADDR;
               state_in  = S_RESP;
            end else if (stat.addr_hit) begin
               if (stat.is_free) begin
                  status_in = ST_ALREADY_FREE;
                  state_in  = S_RESP;
               end else begin
                  cmd      = CMD_F_GRAB;
                  state_in = S_F_RDNX;
               end
            end else if (stat.addr_passed) begin
               status_in = ST_BAD_ADDR;
               state_in  = S_RESP;
            end else begin
               cmd      = CMD_F_STEP;
               state_in = S_F_RD;
            end
         end
         S_F_RDNX: begin
            cmd      = CMD_RD_POS;
            state_in = S_F_EVNX;
         end
         S_F_EVNX: begin
            if (!stat.at_end) begin
               cmd = CMD_F_NEXT;
            end
            state_in = S_F_CHKP;
         end
         S_F_CHKP: begin
            if (stat.pfree_ok) begin
               cmd      = CMD_RD_PFTR;
               state_in = S_F_EVPF;
            end else begin
               state_in = S_F_WHDR;
            end
         end
         S_F_EVPF: begin
            if (stat.ps_ok) begin
               cmd      = CMD_F_PMERGE;
               state_in = S_F_RDH;
            end else begin
               state_in = S_F_WHDR;
            end
         end
         S_F_RDH: begin
            cmd      = CMD_RD_H;
            state_in = S_F_PBIT;
         end
         S_F_PBIT: begin
            cmd      = CMD_F_PBIT;
            state_in = S_F_WHDR;
         end
         S_F_WHDR: begin
            cmd      = CMD_F_WHDR;
            state_in = S_F_WFTR;
         end
         S_F_WFTR: begin
            cmd      = CMD_F_WFTR;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd      = CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs; reset formats the heap first.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FMT_HDR;
         boot_ff   <= 1'b1;
         status_ff <= ST_OK;
         waddr_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         boot_ff   <= boot_in;
         status_ff <= status_in;
         waddr_ff  <= waddr_in;
      end
   end

   assign req_ready     = state_ff == S_IDLE;
   assign ctl.cmd       = cmd;
   assign ctl.status    = status_ff;
   assign ctl.with_addr = waddr_ff;

endmodule

// ===== hw/rtl/bfa_checker.sv =====
// Port-level checker of the allocator and its bind to the top level.
`timescale 1ns / 1ps

module bfa_checker import bfa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_payload_addr,
   input logic [2:0]  rsp_status
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // The heap is being formatted in the cycle after reset.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken while heap is formatted after reset");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted during processing");

   // Only a successful response carries an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_payload_addr == 16'd0)
      else $error("failed response carries an address");

   // Status codes stay in the defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_ALREADY_FREE)
      else $error("undefined response status");

endmodule

bind best_fit_heap_allocator bfa_checker u_bfa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_payload_addr (rsp_ch.payload_addr),
   .rsp_status       (rsp_ch.status)
);

// ===== test/best_fit_heap_allocator_test.sv =====
// Self-checking testbench of the best-fit heap allocator.
`timescale 1ns / 1ps

module best_fit_heap_allocator_test;
   import bfa_pkg::*;

   localparam int MEM_WORDS = 16384;
   localparam int MEM_BYTES = MEM_WORDS * 4;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [15:0] payload_addr;
      logic [2:0]  status;
   } alloc_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [16:0] csr_wr_data;

   bfa_req_if req_ch ();
   bfa_rsp_if rsp_ch ();

   best_fit_heap_allocator #(.HEAP_WORDS(MEM_WORDS)) u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data));

   // Shadow heap and region register of the predictor.
   logic [31:0] shadow_heap [MEM_WORDS];
   logic [16:0] shadow_region;
   alloc_result_type expected_results [$];
   // Payload addresses currently handed out, used to aim free requests.
   logic [15:0] live_blocks [$];
   int mismatch_count;
   int result_count;
   int send_idle_pct;
   int recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic logic [31:0] heap_rd(int unsigned b);
      int unsigned i;
      i = b >> 2;
      return (i < MEM_WORDS) ? shadow_heap[i] : 32'd0;
   endfunction

   function automatic void heap_wr(int unsigned b, logic [31:0] v);
      int unsigned i;
      i = b >> 2;
      if (i < MEM_WORDS) shadow_heap[i] = v;
   endfunction

   function automatic bit walk_done(int unsigned pos);
      logic [31:0] w;
      longint unsigned s;
      w = heap_rd(pos);
      s = 64'(w & SIZE_MASK);
      if (w == HEAP_TAIL || s < 8) return 1'b1;
      return (longint'(pos) + s + 4) > MEM_BYTES;
   endfunction

   function automatic void layout_heap();
      int unsigned r, blk;
      r = shadow_region & ~17'd7;
      if (r > (MEM_BYTES & ~7)) r = MEM_BYTES & ~7;
      if (r > 65536) r = 65536;
      if (r < 16) r = 16;
      blk = r - 8;
      heap_wr(4, blk | 2);
      heap_wr(blk, blk);
      heap_wr(4 + blk, HEAP_TAIL);
   endfunction

   function automatic alloc_result_type predict_alloc(int unsigned req);
      alloc_result_type res;
      int unsigned need, pos, best, bsz, rem, pbit, s, nx;
      logic [31:0] w;
      bit found;
      res = '0;
      found = 0; best = 0; bsz = 0; pos = 4;
      if (req == 0) begin
         res.status = ST_BAD_SIZE;
         return res;
      end
      need = (req + 11) & ~7;
      while (!walk_done(pos)) begin
         w = heap_rd(pos);
         s = w & SIZE_MASK;
         if (w[0] == 1'b0 && s >= need && (!found || s < bsz)) begin
            found = 1; best = pos; bsz = s;
         end
         pos += s;
      end
      if (!found) begin
         res.status = ST_NO_FIT;
         return res;
      end
      pbit = heap_rd(best) & 2;
      rem = bsz - need;
      if (rem >= 8) begin
         heap_wr(best, need | pbit | 1);
         heap_wr(best + need, rem | 2);
         heap_wr(best + need + rem - 4, rem);
      end else begin
         nx = best + bsz;
         heap_wr(best, bsz | pbit | 1);
         if (!walk_done(nx)) heap_wr(nx, heap_rd(nx) | 2);
      end
      res.payload_addr = 16'(best + 4);
      res.status = ST_OK;
      return res;
   endfunction

   function automatic alloc_result_type predict_free(int unsigned a);
      alloc_result_type res;
      int unsigned pos, h, s, p, nx, ps;
      logic [31:0] w, nw;
      bit found;
      res = '0;
      pos = 4; found = 0;
      if (a == 0 || (a & 7) != 0) begin
         res.status = ST_BAD_ADDR;
         return res;
      end
      while (!walk_done(pos)) begin
         if (pos + 4 == a) begin
            found = 1;
            break;
         end
         if (pos + 4 > a) break;
         pos += heap_rd(pos) & SIZE_MASK;
      end
      if (!found) begin
         res.status = ST_BAD_ADDR;
         return res;
      end
      w = heap_rd(pos);
      if (w[0] == 1'b0) begin
         res.status = ST_ALREADY_FREE;
         return res;
      end
      h = pos; s = w & SIZE_MASK; p = w & 2; nx = h + s;
      if (!walk_done(nx)) begin
         nw = heap_rd(nx) & ~32'd2;
         heap_wr(nx, nw);
         if (nw[0] == 1'b0) s += nw & SIZE_MASK;
      end
      if (p == 0 && h >= 8) begin
         ps = heap_rd(h - 4) & SIZE_MASK;
         if (ps >= 8 && ps <= h - 4) begin
            h -= ps; s += ps; p = heap_rd(h) & 2;
         end
      end
      heap_wr(h, s | p);
      heap_wr(h + s - 4, s);
      res.status = ST_OK;
      return res;
   endfunction

   function automatic alloc_result_type predict_request(logic [1:0] op,
         logic [15:0] nbytes, logic [15:0] addr);
      alloc_result_type res;
      res = '0;
      case (op)
         OP_ALLOC: res = predict_alloc(32'(nbytes));
         OP_FREE: res = predict_free(32'(addr));
         OP_FORMAT: layout_heap();
         default: res = '0;
      endcase
      return res;
   endfunction

   // Send one request transaction and queue its expected response.
   // Valid stays high after acceptance until the next idle cycle or drain,
   // while the block is busy and not ready.
   task automatic send_request(logic [1:0] op, logic [15:0] nbytes, logic [15:0] addr);
      alloc_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.req_bytes <= nbytes;
      req_ch.free_addr <= addr;
      do @(posedge clock); while (!req_ch.ready);
      res = predict_request(op, nbytes, addr);
      expected_results.push_back(res);
      if (op == OP_ALLOC && res.status == ST_OK) live_blocks.push_back(res.payload_addr);
      if (op == OP_FORMAT) live_blocks = {};
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_region(logic [16:0] value);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_region = value;
   endtask

   task automatic free_random_live();
      int k;
      logic [15:0] a;
      if (live_blocks.size() == 0) begin
         send_request(OP_FREE, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
         return;
      end
      k = $urandom_range(live_blocks.size() - 1);
      a = live_blocks[k];
      live_blocks.delete(k);
      send_request(OP_FREE, 16'($urandom), a);
   endtask

   // Check each response transaction against the oldest expectation.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response addr=%h status=%0d",
                        rsp_ch.payload_addr, rsp_ch.status);
         end else begin
            want = expected_results.pop_front();
            if (want.payload_addr !== rsp_ch.payload_addr || want.status !== rsp_ch.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected addr=%h status=%0d, got addr=%h status=%0d",
                           want.payload_addr, want.status, rsp_ch.payload_addr, rsp_ch.status);
            end
         end
      end
   end

   // Receiver stalls at the current rate.
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic test_directed();
      send_request(OP_ALLOC, 16'd0, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd0);
      send_request(OP_FREE, 16'd12, 16'd12);
      send_request(OP_FREE, 16'hFFF8, 16'hFFF8);
      send_request(OP_ALLOC, 16'd1, 16'hFFFF);
      send_request(OP_ALLOC, 16'd4, 16'h0000);
      send_request(OP_ALLOC, 16'd5, 16'h5555);
      send_request(OP_FREE, 16'hAAAA, 16'd16);
      send_request(OP_FREE, 16'h0, 16'd16);
      send_request(OP_FREE, 16'h0, 16'd8);
      send_request(OP_ALLOC, 16'hFFFF, 16'h0);
      send_request(OP_UNUSED, 16'hFFFF, 16'hFFFF);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      send_request(OP_ALLOC, 16'd65524, 16'h0);
      send_request(OP_ALLOC, 16'd1, 16'h0);
      send_request(OP_FREE, 16'h0, 16'd8);
      send_request(OP_ALLOC, 16'd65524, 16'h0);
      send_request(OP_FORMAT, 16'h0, 16'h0);
   endtask

   task automatic test_small_region();
      write_region(17'd0);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      send_request(OP_ALLOC, 16'd4, 16'h0);
      send_request(OP_ALLOC, 16'd1, 16'h0);
      send_request(OP_FREE, 16'h0, 16'd8);
      send_request(OP_ALLOC, 16'd5, 16'h0);
      write_region(17'h1FFFF);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      send_request(OP_ALLOC, 16'd40000, 16'h0);
   endtask

   // Random well-formed traffic with some noise, in one idling phase.
   task automatic test_random_phase(int count, int idle_pct, int stall_pct);
      int n, sel;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         if (sel < 45)
            send_request(OP_ALLOC, ($urandom_range(3) == 0) ?
                         16'($urandom_range(65535)) : 16'($urandom_range(1, 300)),
                         16'($urandom));
         else if (sel < 85) free_random_live();
         else if (sel < 92)
            send_request(OP_FREE, 16'($urandom), 16'($urandom_range(65535)));
         else if (sel < 95) send_request(OP_FORMAT, 16'($urandom), 16'($urandom));
         else if (sel < 97) send_request(OP_UNUSED, 16'($urandom), 16'($urandom));
         else send_request(OP_ALLOC, 16'd0, 16'($urandom));
      end
   endtask

   // Pause until every outstanding response has arrived, then resume.
   task automatic test_drain_pause();
      wait_drained();
      send_request(OP_ALLOC, 16'd64, 16'h0);
      free_random_live();
   endtask

   initial begin
      int i;
      for (i = 0; i < MEM_WORDS; i++) shadow_heap[i] = '0;
      shadow_region = REGION_RESET;
      layout_heap();
      mismatch_count = 0;
      result_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_ALLOC;
      req_ch.req_bytes <= '0;
      req_ch.free_addr <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_small_region();
      write_region(17'd2048);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      test_random_phase(450, 0, 0);
      test_drain_pause();
      write_region(17'd513);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      test_random_phase(450, 80, 0);
      write_region(17'd16384);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      test_random_phase(450, 0, 80);
      write_region(17'd65536);
      send_request(OP_FORMAT, 16'h0, 16'h0);
      test_random_phase(450, 6, 6);
      test_drain_pause();
      recv_stall_pct = 0;
      wait_drained();

      $display("Covered %0d responses over directed edges, four region sizes and four idling phases.",
               result_count);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
